/* rtl/core/pip_pkg.sv */
// Shared types and constants for the point-in-polygon test unit.
package pip_pkg;

	localparam int unsigned MAX_VERTICES_DEF = 1024;
	localparam int LIM_W     = 17;   // holds any vertex limit up to 65536
	localparam int COORD_W   = 32;
	localparam int IDX_W     = 10;
	localparam int CNT_W     = 11;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int MAG_W     = COORD_W;
	localparam int PROD_W    = 2 * MAG_W;
	localparam int VTX_W     = 2 * COORD_W;
	localparam int S_TDATA_W = ((IDX_W + 2 * COORD_W + 7) / 8) * 8;
	localparam int M_TDATA_W = 8;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// read-side tags that go with each vertex word from the store
	typedef struct packed {
		logic clr;    // new query: clear the crossing flag
		logic vld;    // vertex word present
		logic first;  // word is the wrap vertex (last one in use)
		logic last;   // word is the final vertex of the walk
	} pip_ctl_t;

	typedef struct packed {
		logic done;   // walk finished, flag is final
		logic parity; // odd number of crossings so far
	} pip_sts_t;

endpackage

/* rtl/core/pip_vertex_mem.sv */
// Vertex store: one write port, one registered read port.
module pip_vertex_mem #(
	parameter int unsigned DEPTH = pip_pkg::MAX_VERTICES_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [pip_pkg::VTX_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [pip_pkg::VTX_W-1:0] rd_data
);
	import pip_pkg::*;

	logic [VTX_W-1:0] mem [DEPTH];
	logic [VTX_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/core/pip_edge_pipe.sv */
// Edge crossing pipeline: straddle test, cross-multiplied compare, parity flag.
module pip_edge_pipe (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pip_pkg::pip_ctl_t                 ctl,
	input  logic signed [pip_pkg::COORD_W-1:0] px,
	input  logic signed [pip_pkg::COORD_W-1:0] py,
	input  logic [pip_pkg::VTX_W-1:0]         vtx,
	output pip_pkg::pip_sts_t                 sts
);
	import pip_pkg::*;

	function automatic logic [MAG_W-1:0] mag_of(input logic signed [DIFF_W-1:0] d);
		logic signed [DIFF_W-1:0] t;
		t = d[DIFF_W-1] ? -d : d;
		return t[MAG_W-1:0];
	endfunction

	// stage 1: current vertex from store, previous vertex held here
	logic signed [COORD_W-1:0] xi, yi, prev_x_q, prev_y_q;
	logic signed [DIFF_W-1:0]  dx_p, dx_e, dy_e, dy_p;
	logic signed [DIFF_W-1:0]  l1, l2, r1, r2;
	logic                      straddle, dy_pos, e_vld;

	// stage 2: magnitudes and product signs
	logic                      cnt_s2, last_s2, nl_s2, nr_s2;
	logic [MAG_W-1:0]          ml1_s2, ml2_s2, mr1_s2, mr2_s2;

	// stage 3: products
	logic                      cnt_s3, last_s3, nl_s3, nr_s3;
	logic [PROD_W-1:0]         pl_s3, pr_s3;
	logic                      an, bn, left;

	logic                      inside_q, done_q;

	assign xi = vtx[COORD_W-1:0];
	assign yi = vtx[VTX_W-1:COORD_W];
	assign e_vld = ctl.vld & ~ctl.first;

	always_comb begin
		dx_p = {px[COORD_W-1], px} - {xi[COORD_W-1], xi};
		dx_e = {prev_x_q[COORD_W-1], prev_x_q} - {xi[COORD_W-1], xi};
		dy_e = {prev_y_q[COORD_W-1], prev_y_q} - {yi[COORD_W-1], yi};
		dy_p = {py[COORD_W-1], py} - {yi[COORD_W-1], yi};
		straddle = ((yi <= py) && (py < prev_y_q)) || ((prev_y_q <= py) && (py < yi));
		dy_pos = prev_y_q > yi;
		// left of crossing: (px-xi)*dy < (xj-xi)*(py-yi), sense flips with dy
		if (dy_pos) begin
			l1 = dx_p;
			l2 = dy_e;
			r1 = dx_e;
			r2 = dy_p;
		end else begin
			l1 = dx_e;
			l2 = dy_p;
			r1 = dx_p;
			r2 = dy_e;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.vld) begin
			prev_x_q <= xi;
			prev_y_q <= yi;
		end
		ml1_s2 <= mag_of(l1);
		ml2_s2 <= mag_of(l2);
		mr1_s2 <= mag_of(r1);
		mr2_s2 <= mag_of(r2);
		nl_s2  <= l1[DIFF_W-1] ^ l2[DIFF_W-1];
		nr_s2  <= r1[DIFF_W-1] ^ r2[DIFF_W-1];
		pl_s3  <= PROD_W'(ml1_s2) * PROD_W'(ml2_s2);
		pr_s3  <= PROD_W'(mr1_s2) * PROD_W'(mr2_s2);
		nl_s3  <= nl_s2;
		nr_s3  <= nr_s2;
	end

	always_comb begin
		an = nl_s3 && (pl_s3 != '0);
		bn = nr_s3 && (pr_s3 != '0);
		if (an != bn) begin
			left = an;
		end else if (!an) begin
			left = pl_s3 < pr_s3;
		end else begin
			left = pl_s3 > pr_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2   <= 1'b0;
			last_s2  <= 1'b0;
			cnt_s3   <= 1'b0;
			last_s3  <= 1'b0;
			inside_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			cnt_s2  <= e_vld & straddle;
			last_s2 <= e_vld & ctl.last;
			cnt_s3  <= cnt_s2;
			last_s3 <= last_s2;
			done_q  <= last_s3;
			if (ctl.clr) begin
				inside_q <= 1'b0;
			end else if (cnt_s3 && left) begin
				inside_q <= ~inside_q;
			end
		end
	end

	assign sts.done   = done_q;
	assign sts.parity = inside_q;

endmodule

/* rtl/core/point_in_polygon_test_unit.sv */
// Top level of the point-in-polygon test unit (crossing number on a stored polygon).
//
// Input stream s_*: s_tuser[0] is the mode (0 = vertex write, 1 = query).
// A write word stores x/y at vertex_index and returns nothing; it is taken
// in idle state, also with a result waiting. A query word carries the
// point and returns one word on m_* with bit 0 = inside (odd crossings).
// cfg_*: writes vertex_count, the number of vertices a query walks (clamped
// to MAX_VERTICES). Always ready; write it only while the unit is idle.
// A query of N vertices reads N+1 words from the vertex store (the wrap
// vertex first, then 0..N-1), one per cycle through its single read port,
// then drains a three-stage compare pipeline before its result is loaded;
// with N = 0 it reads nothing and goes straight to the done state.
// s_tready is low for the whole query. The output register holds one
// result, so a new query may start while the previous result waits; if the
// receiver still stalls when the next walk ends, the unit holds in its done
// state until m_tready frees the register.
// Reset clears vertex_count and all control state; vertex store contents
// are undefined until written.
module point_in_polygon_test_unit #(
	parameter int unsigned MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [9:0] vertex_index, [41:10] x_coord, [73:42] y_coord, [79:74] zero
	input  logic [pip_pkg::S_TDATA_W-1:0] s_tdata,
	// [0] mode
	input  logic [0:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [0] inside_res, [7:1] zero
	output logic [pip_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pip_pkg::CNT_W-1:0]     cfg_data
);
	import pip_pkg::*;

	localparam int AW = $clog2(MAX_VERTICES);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_DONE} state_t;

	state_t                    state_q;
	logic [CNT_W-1:0]          vertex_count_q;
	logic [AW-1:0]             idx_q, last_q;
	logic                      rd_vld_s1, first_s1, last_s1;
	logic                      m_tvalid_q, m_tdata_q;
	logic signed [COORD_W-1:0] px_q, py_q;

	logic                      in_mode, in_acc, wr_en, q_start, rd_en;
	logic [IDX_W-1:0]          in_idx;
	logic [COORD_W-1:0]        in_x, in_y;
	logic [LIM_W-1:0]          cnt_wide, cnt_sat;
	logic                      cnt_zero;
	logic [AW-1:0]             cnt_last, rd_addr;
	logic [VTX_W-1:0]          rd_data;
	pip_ctl_t                  ctl;
	pip_sts_t                  sts;

	assign in_mode = s_tuser[0];
	assign in_idx  = s_tdata[IDX_W-1:0];
	assign in_x    = s_tdata[IDX_W +: COORD_W];
	assign in_y    = s_tdata[IDX_W+COORD_W +: COORD_W];

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid & s_tready;
	assign wr_en     = in_acc && (in_mode == MODE_WRITE) &&
	                   (LIM_W'(in_idx) < LIM_W'(MAX_VERTICES));
	assign q_start   = in_acc && (in_mode == MODE_QUERY);

	// count clamp to store size
	assign cnt_wide = LIM_W'(vertex_count_q);
	assign cnt_sat  = (cnt_wide > LIM_W'(MAX_VERTICES)) ? LIM_W'(MAX_VERTICES) : cnt_wide;
	assign cnt_zero = (cnt_sat == '0);
	assign cnt_last = AW'(cnt_sat - LIM_W'(1));

	// wrap vertex is read on the query's accept cycle, then 0..N-1
	assign rd_en   = (q_start && !cnt_zero) || (state_q == ST_RUN);
	assign rd_addr = (state_q == ST_RUN) ? idx_q : cnt_last;

	pip_vertex_mem #(
		.DEPTH (MAX_VERTICES),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(in_idx)),
		.wr_data ({in_y, in_x}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign ctl.clr   = q_start;
	assign ctl.vld   = rd_vld_s1;
	assign ctl.first = first_s1;
	assign ctl.last  = last_s1;

	pip_edge_pipe u_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.px     (px_q),
		.py     (py_q),
		.vtx    (rd_data),
		.sts    (sts)
	);

	always_ff @(posedge clk) begin
		if (q_start) begin
			px_q <= in_x;
			py_q <= in_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			vertex_count_q <= '0;
			idx_q          <= '0;
			last_q         <= '0;
			rd_vld_s1      <= 1'b0;
			first_s1       <= 1'b0;
			last_s1        <= 1'b0;
			m_tvalid_q     <= 1'b0;
			m_tdata_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				vertex_count_q <= cfg_data;
			end
			rd_vld_s1 <= rd_en;
			first_s1  <= (state_q == ST_IDLE);
			last_s1   <= (state_q == ST_RUN) && (idx_q == last_q);
			// load a finished result, or free the register once taken
			if ((state_q == ST_DONE) && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= sts.parity;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_start) begin
						idx_q   <= '0;
						last_q  <= cnt_last;
						state_q <= cnt_zero ? ST_DONE : ST_RUN;
					end
				end
				ST_RUN: begin
					if (idx_q == last_q) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (sts.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'(m_tdata_q);

endmodule

/* rtl/core/pip_checker.sv */
// Port-level checks for the point-in-polygon test unit, bound to the top level.
module pip_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [0:0]                    s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [pip_pkg::M_TDATA_W-1:0] m_tdata
);
	import pip_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed under stall");

	// a query word occupies the unit
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == MODE_QUERY) |=> !s_tready)
		else $error("unit ready right after taking a query");

	// a vertex write never blocks the input
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == MODE_WRITE) |=> s_tready)
		else $error("vertex write stalled the input");

	// a new result appears as the unit returns to idle
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result shown while a query is still running");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[M_TDATA_W-1:1] == '0))
		else $error("result padding not zero");

endmodule

bind point_in_polygon_test_unit pip_checker u_pip_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
